// ===== rtl/sdp_pkg.sv =====
package sdp_pkg;

	// Data field length of one sample dump data packet.
	localparam int DATA_FIELD_BYTES = 120;

	// Fixed packet bytes.
	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_NONRT = 8'h7E;
	localparam logic [7:0] DUMP_DATA   = 8'h02;
	localparam logic [7:0] SYSEX_END   = 8'hF7;

	// Configuration register indexes.
	localparam logic CFG_DEVICE_ID    = 1'b0;
	localparam logic CFG_SAMPLE_WIDTH = 1'b1;

	// Work for one sample as the front hands it to the back.
	typedef struct packed {
		logic        hdr;      // sample opens a packet
		logic [6:0]  dev_id;
		logic [6:0]  pkt_num;
		logic [34:0] groups;   // 7-bit groups, first group in the top bits
		logic [2:0]  ngrp;     // groups that fit in the data field
		logic [6:0]  npad;     // zero bytes after the groups
		logic        close;    // packet closes after this sample
		logic        last;
	} cmd_t;

	// One beat on the result side.
	typedef struct packed {
		logic [7:0][7:0] bytes;
		logic [3:0]      count;
		logic            packet_end;
		logic            transfer_end;
		logic            run_last;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HEAD,
		BK_DATA,
		BK_PAD,
		BK_SUM,
		BK_END
	} back_state_t;

endpackage

// ===== rtl/sdp_front.sv =====
module sdp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [6:0]    cfg_data,
	input  logic          push,
	input  logic [31:0]   sample_value,
	input  logic          last_sample,
	input  logic          q_full,
	output logic          q_push,
	output sdp_pkg::cmd_t cmd
);

	logic [6:0]  device_id_q;
	logic [1:0]  width_code_q;
	logic [6:0]  data_cnt_q;
	logic [6:0]  pkt_num_q;

	logic        accept;
	logic [34:0] aligned;
	logic [2:0]  grp_total;
	logic [6:0]  room;
	logic [2:0]  ngrp;
	logic [6:0]  data_after;
	logic        close;

	assign accept = push & ~q_full;
	assign q_push = accept;

	// Left justification into 7-bit groups, with offset binary conversion of the 16-, 24- and 32-bit widths.
	always_comb begin
		unique case (width_code_q)
			2'd0: begin
				aligned   = {sample_value[7:0], 27'd0};
				grp_total = 3'd2;
			end
			2'd1: begin
				aligned   = {~sample_value[15], sample_value[14:0], 19'd0};
				grp_total = 3'd3;
			end
			2'd2: begin
				aligned   = {~sample_value[23], sample_value[22:0], 11'd0};
				grp_total = 3'd4;
			end
			default: begin
				aligned   = {~sample_value[31], sample_value[30:0], 3'd0};
				grp_total = 3'd5;
			end
		endcase
	end

	// Room in the data field and the closing decision.
	always_comb begin
		room       = 7'(sdp_pkg::DATA_FIELD_BYTES) - data_cnt_q;
		ngrp       = ({4'd0, grp_total} > room) ? room[2:0] : grp_total;
		data_after = data_cnt_q + {4'd0, ngrp};
		close      = last_sample
			|| (({1'b0, data_after} + {5'd0, grp_total}) > 8'(sdp_pkg::DATA_FIELD_BYTES));
	end

	// Command for the back.
	always_comb begin
		cmd.hdr     = (data_cnt_q == 7'd0);
		cmd.dev_id  = device_id_q;
		cmd.pkt_num = pkt_num_q;
		cmd.groups  = aligned;
		cmd.ngrp    = ngrp;
		cmd.npad    = close ? 7'(sdp_pkg::DATA_FIELD_BYTES) - data_after : 7'd0;
		cmd.close   = close;
		cmd.last    = last_sample;
	end

	// Configuration registers and packet position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q  <= 7'd0;
			width_code_q <= 2'd1;
			data_cnt_q   <= 7'd0;
			pkt_num_q    <= 7'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sdp_pkg::CFG_DEVICE_ID:    device_id_q  <= cfg_data;
					sdp_pkg::CFG_SAMPLE_WIDTH: width_code_q <= cfg_data[1:0];
				endcase
			end
			if (accept) begin
				if (close) begin
					data_cnt_q <= 7'd0;
					pkt_num_q  <= last_sample ? 7'd0 : pkt_num_q + 7'd1;
				end else begin
					data_cnt_q <= data_after;
				end
			end
		end
	end

endmodule

// ===== rtl/sdp_cmd_fifo.sv =====
module sdp_cmd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sdp_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output sdp_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sdp_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sdp_back.sv =====
module sdp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sdp_pkg::cmd_t    q_data,
	output logic             q_pop,
	input  logic             pop,
	output logic             out_vld,
	output sdp_pkg::result_t result
);

	sdp_pkg::back_state_t state_q;
	sdp_pkg::back_state_t state_d;
	sdp_pkg::cmd_t        cmd_q;
	sdp_pkg::result_t     out_q;
	logic [6:0]           idx_q;
	logic [2:0]           cnt_q;
	logic [6:0][7:0]      asm_q;
	logic [6:0]           csum_q;
	logic                 out_vld_q;

	logic                 active;
	logic [7:0]           byte_val;
	logic [6:0]           grp_sel;
	logic                 last_idx;
	logic [3:0]           rem;
	logic                 emit;
	logic                 go;
	logic                 out_free;
	logic                 run_last;
	sdp_pkg::result_t     built;

	assign out_free = ~out_vld_q | pop;
	assign q_pop    = (state_q == sdp_pkg::BK_IDLE) & ~q_empty;
	assign out_vld  = out_vld_q;
	assign result   = out_q;

	// Data group selection.
	always_comb begin
		unique case (idx_q[2:0])
			3'd0:    grp_sel = cmd_q.groups[34:28];
			3'd1:    grp_sel = cmd_q.groups[27:21];
			3'd2:    grp_sel = cmd_q.groups[20:14];
			3'd3:    grp_sel = cmd_q.groups[13:7];
			3'd4:    grp_sel = cmd_q.groups[6:0];
			default: grp_sel = 7'd0;
		endcase
	end

	// Byte of the current step and what follows it in this sample.
	always_comb begin
		active   = 1'b1;
		byte_val = 8'd0;
		last_idx = 1'b0;
		rem      = 4'd0;
		unique case (state_q)
			sdp_pkg::BK_IDLE: begin
				active = 1'b0;
			end
			sdp_pkg::BK_HEAD: begin
				unique case (idx_q[2:0])
					3'd0:    byte_val = sdp_pkg::SYSEX_START;
					3'd1:    byte_val = sdp_pkg::SYSEX_NONRT;
					3'd2:    byte_val = {1'b0, cmd_q.dev_id};
					3'd3:    byte_val = sdp_pkg::DUMP_DATA;
					default: byte_val = {1'b0, cmd_q.pkt_num};
				endcase
				last_idx = (idx_q == 7'd4);
				rem      = {1'b0, 3'd4 - idx_q[2:0]} + {1'b0, cmd_q.ngrp};
			end
			sdp_pkg::BK_DATA: begin
				byte_val = {1'b0, grp_sel};
				last_idx = (idx_q[2:0] == cmd_q.ngrp - 3'd1);
				rem      = {1'b0, cmd_q.ngrp - 3'd1 - idx_q[2:0]};
			end
			sdp_pkg::BK_PAD: begin
				last_idx = (idx_q == cmd_q.npad - 7'd1);
			end
			sdp_pkg::BK_SUM: begin
				byte_val = {1'b0, csum_q};
				last_idx = 1'b1;
			end
			sdp_pkg::BK_END: begin
				byte_val = sdp_pkg::SYSEX_END;
				last_idx = 1'b1;
			end
			default: begin
				active = 1'b0;
			end
		endcase
		emit     = active && ((cnt_q == 3'd7) || (state_q == sdp_pkg::BK_END));
		go       = active && (!emit || out_free);
		run_last = cmd_q.close ? (state_q == sdp_pkg::BK_END) : (rem < 4'd8);
	end

	// Result beat assembled from the pending bytes and the current byte.
	always_comb begin
		for (int i = 0; i < 7; i++) begin
			built.bytes[i] = asm_q[i] | ((cnt_q == 3'(i)) ? byte_val : 8'd0);
		end
		built.bytes[7]      = (cnt_q == 3'd7) ? byte_val : 8'd0;
		built.count         = {1'b0, cnt_q} + 4'd1;
		built.packet_end    = (state_q == sdp_pkg::BK_END);
		built.transfer_end  = (state_q == sdp_pkg::BK_END) && cmd_q.last;
		built.run_last      = run_last;
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdp_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = q_data.hdr ? sdp_pkg::BK_HEAD : sdp_pkg::BK_DATA;
				end
			end
			sdp_pkg::BK_HEAD: begin
				if (go && last_idx) begin
					state_d = sdp_pkg::BK_DATA;
				end
			end
			sdp_pkg::BK_DATA: begin
				if (go && last_idx) begin
					if (!cmd_q.close) begin
						state_d = sdp_pkg::BK_IDLE;
					end else if (cmd_q.npad != 7'd0) begin
						state_d = sdp_pkg::BK_PAD;
					end else begin
						state_d = sdp_pkg::BK_SUM;
					end
				end
			end
			sdp_pkg::BK_PAD: begin
				if (go && last_idx) begin
					state_d = sdp_pkg::BK_SUM;
				end
			end
			sdp_pkg::BK_SUM: begin
				if (go) begin
					state_d = sdp_pkg::BK_END;
				end
			end
			sdp_pkg::BK_END: begin
				if (go) begin
					state_d = sdp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = sdp_pkg::BK_IDLE;
			end
		endcase
	end

	// Command register and result beat register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (go && emit) begin
			out_q <= built;
		end
	end

	// Sequencer, byte assembly, checksum and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sdp_pkg::BK_IDLE;
			idx_q     <= 7'd0;
			cnt_q     <= 3'd0;
			asm_q     <= '0;
			csum_q    <= 7'd0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go) begin
				idx_q <= last_idx ? 7'd0 : idx_q + 7'd1;
				if (emit) begin
					asm_q <= '0;
					cnt_q <= 3'd0;
				end else begin
					asm_q[cnt_q] <= byte_val;
					cnt_q        <= cnt_q + 3'd1;
				end
				if (state_q == sdp_pkg::BK_HEAD && idx_q == 7'd0) begin
					csum_q <= 7'd0;
				end else if (state_q == sdp_pkg::BK_HEAD || state_q == sdp_pkg::BK_DATA) begin
					csum_q <= csum_q ^ byte_val[6:0];
				end
			end
			if (go && emit) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/sds_data_packet_encoder.sv =====
// Sample dump data packet encoder. Samples enter on a queue-style port and
// leave as 127-byte data packets (F0 7E id 02 number, 120 data bytes,
// checksum, F7) in beats of up to eight bytes. The front classifies a
// sample in the cycle it is accepted and queues it (CMD_DEPTH entries);
// the back sequencer then writes one packet byte per cycle into the beat
// being assembled, after loading the sample in its idle state. A sample
// gives 2 to 5 data groups for 8- to 32-bit samples, after five header
// bytes when it opens a packet and before the padding, checksum and F7
// when it closes one. Byte writing stalls when a beat is complete while
// the previous beat is still held on the result port. The user must set
// the sample width and device id through the write port only while the
// block is idle; the block itself does not enforce this.
module sds_data_packet_encoder #(
	parameter int CMD_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [31:0] sample_value,
	input  logic        last_sample,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  byte_0,
	output logic [7:0]  byte_1,
	output logic [7:0]  byte_2,
	output logic [7:0]  byte_3,
	output logic [7:0]  byte_4,
	output logic [7:0]  byte_5,
	output logic [7:0]  byte_6,
	output logic [7:0]  byte_7,
	output logic [3:0]  beat_bytes,
	output logic        packet_end,
	output logic        transfer_end,
	output logic        run_last
);

	sdp_pkg::cmd_t    front_cmd;
	sdp_pkg::cmd_t    back_cmd;
	sdp_pkg::result_t result;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	logic             out_vld;

	assign full  = q_full;
	assign empty = ~out_vld;

	sdp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.sample_value (sample_value),
		.last_sample  (last_sample),
		.q_full       (q_full),
		.q_push       (q_push),
		.cmd          (front_cmd)
	);

	sdp_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (front_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (back_cmd),
		.empty   (q_empty)
	);

	sdp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (back_cmd),
		.q_pop   (q_pop),
		.pop     (pop),
		.out_vld (out_vld),
		.result  (result)
	);

	// Result beat onto the byte ports.
	assign byte_0       = result.bytes[0];
	assign byte_1       = result.bytes[1];
	assign byte_2       = result.bytes[2];
	assign byte_3       = result.bytes[3];
	assign byte_4       = result.bytes[4];
	assign byte_5       = result.bytes[5];
	assign byte_6       = result.bytes[6];
	assign byte_7       = result.bytes[7];
	assign beat_bytes   = result.count;
	assign packet_end   = result.packet_end;
	assign transfer_end = result.transfer_end;
	assign run_last     = result.run_last;

endmodule
